// File: design/unesc_pkg.sv
`timescale 1ns / 1ps

package unesc_pkg;

    // escape mode, one-hot
    typedef enum logic [2:0] {
        M_PLAIN = 3'b001,
        M_ESC   = 3'b010,
        M_HEX   = 3'b100
    } t_mode;

    typedef struct packed {
        t_mode       mode;
        logic        short_hex;
        logic [2:0]  digit_count;
        logic [15:0] code_value;
    } t_state;

    // up to four result bytes of one input transfer
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
        logic            has_byte;
        logic            end_of_text;
    } t_result;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_1      = 8'h31;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_V      = 8'h76;

    localparam logic [7:0] CC_BEL = 8'h07;
    localparam logic [7:0] CC_BS  = 8'h08;
    localparam logic [7:0] CC_FF  = 8'h0C;
    localparam logic [7:0] CC_LF  = 8'h0A;
    localparam logic [7:0] CC_CR  = 8'h0D;
    localparam logic [7:0] CC_HT  = 8'h09;
    localparam logic [7:0] CC_VT  = 8'h0B;

    // utf-8 replacement character
    localparam logic [7:0] REPL_B0 = 8'hEF;
    localparam logic [7:0] REPL_B1 = 8'hBF;
    localparam logic [7:0] REPL_B2 = 8'hBD;

    localparam logic [2:0] LIMIT_X = 3'd2;
    localparam logic [2:0] LIMIT_U = 3'd4;

    localparam t_state STATE_CLEAR = '{mode: M_PLAIN, short_hex: 1'b0,
                                       digit_count: 3'd0, code_value: 16'd0};

endpackage

// File: design/unesc_decode.sv
`timescale 1ns / 1ps

module unesc_decode (
    input  unesc_pkg::t_state  i_state,
    input  logic [7:0]         i_byte,
    input  logic               i_last,
    output unesc_pkg::t_state  o_next,
    output unesc_pkg::t_result o_res
);

    logic [3:0]  hex_d;
    logic        hex_ok;
    logic [2:0]  limit;
    logic [2:0]  cnt_inc;
    logic [15:0] code_new;

    unesc_pkg::t_state ns;
    logic        fin;
    logic [15:0] fin_code;
    logic        fin_short;
    logic [7:0]  e_b0;
    logic [7:0]  e_b1;
    logic [1:0]  e_n;

    logic [2:0][7:0] f_b;
    logic [1:0]      f_n;
    logic [2:0]      total;

    // hex digit value
    always_comb begin
        hex_ok = 1'b1;
        hex_d  = 4'd0;
        if (i_byte >= 8'h30 && i_byte <= 8'h39) begin
            hex_d = i_byte[3:0];
        end else if ((i_byte >= 8'h41 && i_byte <= 8'h46) ||
                     (i_byte >= 8'h61 && i_byte <= 8'h66)) begin
            hex_d = i_byte[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign limit    = i_state.short_hex ? unesc_pkg::LIMIT_X : unesc_pkg::LIMIT_U;
    assign cnt_inc  = i_state.digit_count + 3'd1;
    assign code_new = {i_state.code_value[11:0], hex_d};

    // next state and the bytes around a finished hex run
    always_comb begin
        ns        = i_state;
        fin       = 1'b0;
        fin_code  = i_state.code_value;
        fin_short = i_state.short_hex;
        e_b0      = 8'd0;
        e_b1      = 8'd0;
        e_n       = 2'd0;
        unique case (i_state.mode)
            unesc_pkg::M_ESC: begin
                ns.mode = unesc_pkg::M_PLAIN;
                if (i_byte >= unesc_pkg::CH_1 && i_byte <= unesc_pkg::CH_9) begin
                    e_b0 = unesc_pkg::CH_DOLLAR;
                    e_b1 = i_byte;
                    e_n  = 2'd2;
                end else begin
                    e_n = 2'd1;
                    unique case (i_byte) inside
                        unesc_pkg::CH_A: e_b0 = unesc_pkg::CC_BEL;
                        unesc_pkg::CH_B: e_b0 = unesc_pkg::CC_BS;
                        unesc_pkg::CH_F: e_b0 = unesc_pkg::CC_FF;
                        unesc_pkg::CH_N: e_b0 = unesc_pkg::CC_LF;
                        unesc_pkg::CH_R: e_b0 = unesc_pkg::CC_CR;
                        unesc_pkg::CH_T: e_b0 = unesc_pkg::CC_HT;
                        unesc_pkg::CH_V: e_b0 = unesc_pkg::CC_VT;
                        unesc_pkg::CH_BSLASH: begin
                            e_b0 = unesc_pkg::CH_BSLASH;
                            e_b1 = unesc_pkg::CH_BSLASH;
                            e_n  = 2'd2;
                        end
                        unesc_pkg::CH_X, unesc_pkg::CH_U: begin
                            ns.mode        = unesc_pkg::M_HEX;
                            ns.short_hex   = (i_byte == unesc_pkg::CH_X);
                            ns.digit_count = 3'd0;
                            ns.code_value  = 16'd0;
                            e_n            = 2'd0;
                        end
                        default: e_b0 = i_byte;
                    endcase
                end
            end
            unesc_pkg::M_HEX: begin
                if (hex_ok && i_state.digit_count < limit) begin
                    ns.code_value  = code_new;
                    ns.digit_count = cnt_inc;
                    if (cnt_inc >= limit) begin
                        fin      = 1'b1;
                        fin_code = code_new;
                        ns       = unesc_pkg::STATE_CLEAR;
                    end
                end else begin
                    // run ends; a backslash opens a new escape, any other byte is taken as plain text
                    fin = 1'b1;
                    ns  = unesc_pkg::STATE_CLEAR;
                    if (i_byte == unesc_pkg::CH_BSLASH) begin
                        ns.mode = unesc_pkg::M_ESC;
                    end else begin
                        e_b0 = i_byte;
                        e_n  = 2'd1;
                    end
                end
            end
            default: begin
                ns.mode = unesc_pkg::M_PLAIN;
                if (i_byte == unesc_pkg::CH_BSLASH) begin
                    ns.mode = unesc_pkg::M_ESC;
                end else begin
                    e_b0 = i_byte;
                    e_n  = 2'd1;
                end
            end
        endcase
        if (i_last) begin
            if (ns.mode == unesc_pkg::M_HEX) begin
                fin       = 1'b1;
                fin_code  = ns.code_value;
                fin_short = ns.short_hex;
            end
            ns = unesc_pkg::STATE_CLEAR;
        end
    end

    assign o_next = ns;

    // utf-8 encode of the finished code value
    always_comb begin
        f_b = '0;
        f_n = 2'd0;
        if (fin) begin
            if (fin_code == 16'd0) begin
                f_b[0] = fin_short ? unesc_pkg::CH_X : unesc_pkg::CH_U;
                f_n    = 2'd1;
            end else if (fin_code[15:7] == 9'd0) begin
                f_b[0] = fin_code[7:0];
                f_n    = 2'd1;
            end else if (fin_code[15:11] == 5'd0) begin
                f_b[0] = {3'b110, fin_code[10:6]};
                f_b[1] = {2'b10, fin_code[5:0]};
                f_n    = 2'd2;
            end else if (fin_code[15:11] == 5'b11011) begin
                f_b[0] = unesc_pkg::REPL_B0;
                f_b[1] = unesc_pkg::REPL_B1;
                f_b[2] = unesc_pkg::REPL_B2;
                f_n    = 2'd3;
            end else begin
                f_b[0] = {4'b1110, fin_code[15:12]};
                f_b[1] = {2'b10, fin_code[11:6]};
                f_b[2] = {2'b10, fin_code[5:0]};
                f_n    = 2'd3;
            end
        end
    end

    assign total = {1'b0, f_n} + {1'b0, e_n};

    // hex run bytes first, then the bytes of the current character
    always_comb begin
        o_res             = '0;
        o_res.count       = total;
        o_res.has_byte    = 1'b1;
        o_res.end_of_text = i_last;
        for (int i = 0; i < 4; i++) begin
            if (3'(i) < {1'b0, f_n}) begin
                o_res.bytes[i] = f_b[2'(i)];
            end else if (3'(i) == {1'b0, f_n}) begin
                o_res.bytes[i] = e_b0;
            end else begin
                o_res.bytes[i] = e_b1;
            end
        end
        if (i_last && total == 3'd0) begin
            // bare end marker
            o_res.bytes    = '0;
            o_res.count    = 3'd1;
            o_res.has_byte = 1'b0;
        end
    end

endmodule

// File: design/unesc_outbuf.sv
`timescale 1ns / 1ps

module unesc_outbuf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  unesc_pkg::t_result i_res,
    output logic               o_space,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [7:0]         o_m_tdata,
    output logic               o_m_tuser,
    output logic               o_m_tlast
);

    logic               r_valid;
    logic [1:0]         r_idx;
    unesc_pkg::t_result r_res;
    logic               last_beat;

    assign last_beat  = (r_idx == 2'(r_res.count - 3'd1));
    assign o_space    = !r_valid || (i_m_tready && last_beat);
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_res.bytes[r_idx];
    assign o_m_tuser  = r_res.has_byte;
    assign o_m_tlast  = r_res.end_of_text && last_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (r_valid && i_m_tready) begin
            if (last_beat) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// File: design/escape_sequence_unescaper_top.sv
`timescale 1ns / 1ps

// Backslash unescaper for replacement text. Each input transfer carries one text byte; the
// byte is decoded against the escape state in the cycle it is taken, and its results (zero to
// four bytes) land in a result buffer that drives the output one byte per transfer. A byte
// with zero or one result lets the next byte in as it drains, so plain text runs at one
// byte per clock while the output is ready; a byte with n results holds the buffer for n
// output transfers (up to 4) on the single-byte output port, and the input waits for the
// last. \x and \u runs are emitted as UTF-8, a lone surrogate as EF BF BD, and the byte
// marked tlast always gives at least one output transfer with tlast set (a bare end marker
// with tuser low if the text ends with no pending output). No clearing pass after reset.
module escape_sequence_unescaper_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input stream
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] text_byte
    input  logic       i_s_tlast,   // last byte of the text
    // output stream
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tuser,   // [0] has_byte, low for a bare end marker
    output logic       o_m_tlast    // end_of_text
);

    unesc_pkg::t_state  r_state;
    unesc_pkg::t_state  n_state;
    unesc_pkg::t_result dec_res;
    logic               space;
    logic               s_accept;

    // input is taken whenever the buffer is free or drains this cycle
    assign o_s_tready = space;
    assign s_accept   = i_s_tvalid && space;

    unesc_decode u_decode (
        .i_state (r_state),
        .i_byte  (i_s_tdata),
        .i_last  (i_s_tlast),
        .o_next  (n_state),
        .o_res   (dec_res)
    );

    // bytes that only change state load nothing
    unesc_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (s_accept && (dec_res.count != 3'd0)),
        .i_res      (dec_res),
        .o_space    (space),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // escape state advances once per accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= unesc_pkg::STATE_CLEAR;
        end else if (s_accept) begin
            r_state <= n_state;
        end
    end

    // a bare end marker is always the end of the text
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> o_m_tlast)
        else $error("bare end marker without tlast");

    // the final byte always produces output
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tlast) |=> o_m_tvalid)
        else $error("final byte produced no output");

    // text end returns to plain text with a cleared code value
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tlast) |=>
        (r_state.mode == unesc_pkg::M_PLAIN && r_state.code_value == 16'd0))
        else $error("state not cleared at end of text");

    // a hex run never holds a full set of digits
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.mode == unesc_pkg::M_HEX) |->
        (r_state.digit_count < (r_state.short_hex ? unesc_pkg::LIMIT_X
                                                  : unesc_pkg::LIMIT_U)))
        else $error("hex digit count past its limit");

endmodule
